### rtl/fcgi_pkg.sv
package fcgi_pkg;

	localparam int unsigned ID_W = 16;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned SKIP_W = 17;

	localparam logic [7:0] REC_REQ_END = 8'd3;
	localparam logic [7:0] REC_STDOUT = 8'd6;
	localparam logic [7:0] REC_STDERR = 8'd7;

	localparam logic [7:0] LF_BYTE = 8'h0a;
	localparam logic [7:0] SPACE_BYTE = 8'h20;

	typedef enum logic [2:0] {
		KIND_HDR_BYTE = 3'd0,
		KIND_BODY_BYTE = 3'd1,
		KIND_ERR_BYTE = 3'd2,
		KIND_HDR_DONE = 3'd3,
		KIND_RESP_END = 3'd4,
		KIND_EARLY_END = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		RD_HEADERS = 2'd0,
		RD_BODY = 2'd1,
		RD_NOBODY = 2'd2
	} read_phase_t;

	typedef enum logic {
		CFG_OWN_ID = 1'b0,
		CFG_NO_BODY = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [LEN_W-1:0] content_left;
		logic [SKIP_W-1:0] skip_left;
		logic stderr_upd;
		logic stderr_val;
		logic end_hit;
		kind_t end_kind;
	} hdr_dec_t;

endpackage

### rtl/fcgi_hdr_decode.sv
module fcgi_hdr_decode
	import fcgi_pkg::*;
(
	input logic [7:0] rec_type,
	input logic [ID_W-1:0] rec_id,
	input logic [LEN_W-1:0] rec_len,
	input logic [7:0] rec_pad,
	input logic [ID_W-1:0] own_id,
	input read_phase_t read_phase,
	output hdr_dec_t dec
);

	logic id_match;
	logic known_type;
	logic skip_content;
	logic [SKIP_W-1:0] skip_sum;

	assign id_match = (rec_id == own_id);
	assign known_type = (rec_type == REC_STDOUT) || (rec_type == REC_STDERR);
	assign skip_content = !id_match || (read_phase == RD_NOBODY) || !known_type;
	assign skip_sum = {{(SKIP_W-8){1'b0}}, rec_pad} + {{(SKIP_W-LEN_W){1'b0}}, rec_len};

	always_comb begin
		dec.content_left = skip_content ? '0 : rec_len;
		dec.skip_left = skip_content ? skip_sum : {{(SKIP_W-8){1'b0}}, rec_pad};
		dec.stderr_upd = id_match && known_type;
		dec.stderr_val = (rec_type == REC_STDERR);
		dec.end_hit = id_match && (rec_type == REC_REQ_END);
		dec.end_kind = (read_phase == RD_HEADERS) ? KIND_EARLY_END : KIND_RESP_END;
	end

endmodule

### rtl/fastcgi_record_deframer.sv
// FastCGI response deframer for one connection. Takes one response byte per
// cycle and gives at most one item per byte: header byte, body byte, stderr
// byte, headers done, response end or premature end. The state update and
// the result register sit behind a single layer of counter and compare
// logic, so a new byte is accepted in every cycle in which the result
// register is empty or being drained. Records with a foreign request id
// or an unknown type are skipped; after a matching end-request record all
// input is consumed and ignored until reset.
module fastcgi_record_deframer
	import fcgi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata,    // [7:0] data_byte
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [2:0] m_axis_tuser,   // [2:0] out_kind
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_wdata
);

	typedef enum logic [1:0] {
		PH_HDR = 2'd0,
		PH_PAY = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	logic [ID_W-1:0] own_id_q;
	logic no_body_q;

	phase_t phase_q, phase_d;
	logic [2:0] hdr_idx_q;
	logic [7:0] hdr_bytes_q [1:6];
	logic [LEN_W-1:0] content_left_q, content_left_d;
	logic [SKIP_W-1:0] skip_left_q, skip_left_d;
	read_phase_t read_phase_q, read_phase_d;
	logic stderr_q, stderr_d;
	logic line_text_q, line_text_d;

	logic res_valid_q;
	kind_t res_kind_q;
	logic [7:0] res_byte_q;
	logic emit;
	kind_t emit_kind;
	logic [7:0] emit_byte;

	logic accept;
	hdr_dec_t dec;

	assign s_axis_tready = !res_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = res_byte_q;
	assign m_axis_tuser = res_kind_q;

	fcgi_hdr_decode u_hdr_decode (
		.rec_type(hdr_bytes_q[1]),
		.rec_id({hdr_bytes_q[2], hdr_bytes_q[3]}),
		.rec_len({hdr_bytes_q[4], hdr_bytes_q[5]}),
		.rec_pad(hdr_bytes_q[6]),
		.own_id(own_id_q),
		.read_phase(read_phase_q),
		.dec(dec)
	);

	always_comb begin
		phase_d = phase_q;
		content_left_d = content_left_q;
		skip_left_d = skip_left_q;
		read_phase_d = read_phase_q;
		stderr_d = stderr_q;
		line_text_d = line_text_q;
		emit = 1'b0;
		emit_kind = KIND_HDR_BYTE;
		emit_byte = s_axis_tdata;
		case (phase_q)
			PH_HDR: begin
				if (hdr_idx_q == 3'd7) begin
					if (dec.stderr_upd) begin
						stderr_d = dec.stderr_val;
					end
					if (dec.end_hit) begin
						phase_d = PH_DONE;
						content_left_d = '0;
						skip_left_d = '0;
						emit = 1'b1;
						emit_kind = dec.end_kind;
						emit_byte = '0;
					end else begin
						content_left_d = dec.content_left;
						skip_left_d = dec.skip_left;
						phase_d = (dec.content_left != '0 || dec.skip_left != '0)
							? PH_PAY : PH_HDR;
					end
				end
			end
			PH_PAY: begin
				if (content_left_q != '0) begin
					content_left_d = content_left_q - LEN_W'(1);
					if (stderr_q) begin
						emit = 1'b1;
						emit_kind = KIND_ERR_BYTE;
					end else if (read_phase_q == RD_HEADERS) begin
						emit = 1'b1;
						if (s_axis_tdata == LF_BYTE) begin
							if (line_text_q) begin
								line_text_d = 1'b0;
							end else begin
								read_phase_d = no_body_q ? RD_NOBODY : RD_BODY;
								stderr_d = 1'b0;
								line_text_d = 1'b0;
								emit_kind = KIND_HDR_DONE;
								emit_byte = '0;
							end
						end else if (s_axis_tdata == 8'd0 || s_axis_tdata > SPACE_BYTE) begin
							line_text_d = 1'b1;
						end
					end else if (read_phase_q == RD_BODY) begin
						emit = 1'b1;
						emit_kind = KIND_BODY_BYTE;
					end
				end else if (skip_left_q != '0) begin
					skip_left_d = skip_left_q - SKIP_W'(1);
				end
				if (content_left_d == '0 && skip_left_d == '0) begin
					phase_d = PH_HDR;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= 16'd1;
			no_body_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ID: own_id_q <= cfg_wdata[ID_W-1:0];
				CFG_NO_BODY: no_body_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hdr_idx_q <= '0;
			content_left_q <= '0;
			skip_left_q <= '0;
			read_phase_q <= RD_HEADERS;
			stderr_q <= 1'b0;
			line_text_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				content_left_q <= content_left_d;
				skip_left_q <= skip_left_d;
				read_phase_q <= read_phase_d;
				stderr_q <= stderr_d;
				line_text_q <= line_text_d;
				if (phase_q == PH_HDR) begin
					hdr_idx_q <= hdr_idx_q + 3'd1;
				end
			end
			if (accept) begin
				res_valid_q <= emit;
			end else if (m_axis_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_HDR && hdr_idx_q != 3'd0 && hdr_idx_q != 3'd7) begin
			hdr_bytes_q[hdr_idx_q] <= s_axis_tdata;
		end
		if (accept && emit) begin
			res_kind_q <= emit_kind;
			res_byte_q <= emit_byte;
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("deframer left the done phase");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !res_valid_q) |=> !res_valid_q)
		else $error("item produced after response end");

	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> (content_left_q != '0 || skip_left_q != '0))
		else $error("payload phase with nothing left to count");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_kind_q == KIND_HDR_DONE || res_kind_q == KIND_RESP_END
			|| res_kind_q == KIND_EARLY_END)) |-> res_byte_q == 8'd0)
		else $error("marker item carries a nonzero byte");

endmodule

### test/fastcgi_record_deframer_test.sv
module fastcgi_record_deframer_test;
	import fcgi_pkg::*;

	typedef enum logic [1:0] {
		FR_HEAD,
		FR_PAYLOAD,
		FR_CLOSED
	} frame_state_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
	} out_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;

	fastcgi_record_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register shadows
	logic [15:0] own_id = 16'd1;
	bit cfg_no_body = 1'b0;

	// deframer state
	frame_state_t fr_state = FR_HEAD;
	logic [2:0] hidx = 3'd0;
	logic [7:0] hbuf [7];
	logic [15:0] cont_left = 16'd0;
	logic [16:0] skip_cnt = 17'd0;
	read_phase_t rphase = RD_HEADERS;
	bit err_on = 1'b0;
	bit line_text = 1'b0;

	out_item_t pending_out [$];
	logic [7:0] stream_q [$];
	logic [7:0] content_q [$];

	int unsigned n_pushed = 0;
	int unsigned n_accepted = 0;
	int unsigned n_out = 0;
	int unsigned errors = 0;
	int unsigned kind_cnt [8];
	int unsigned send_idle = 30;
	int unsigned recv_idle = 57;
	int unsigned hold_left = 0;
	bit held = 1'b0;
	bit gen_text = 1'b0;
	bit hdr_done_gen = 1'b0;
	bit early_end = 1'b0;
	out_item_t want;

	task automatic want_out(input kind_t k, input logic [7:0] d);
		pending_out.push_back('{kind: k, data: d});
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [15:0] rid;
		logic [15:0] clen;
		logic [16:0] skip;
		case (fr_state)
			FR_HEAD: begin
				if (hidx < 3'd7) begin
					hbuf[hidx] = b;
					hidx++;
				end else begin
					hidx = 3'd0;
					rid = {hbuf[2], hbuf[3]};
					clen = {hbuf[4], hbuf[5]};
					skip = {9'd0, hbuf[6]};
					if (rid == own_id && hbuf[1] == REC_REQ_END) begin
						fr_state = FR_CLOSED;
						cont_left = 16'd0;
						skip_cnt = 17'd0;
						want_out(rphase == RD_HEADERS ? KIND_EARLY_END : KIND_RESP_END, 8'h00);
					end else begin
						if (rid != own_id || rphase == RD_NOBODY) begin
							skip = skip + clen;
							clen = 16'd0;
						end
						if (rid == own_id) begin
							if (hbuf[1] == REC_STDOUT)
								err_on = 1'b0;
							else if (hbuf[1] == REC_STDERR)
								err_on = 1'b1;
							else begin
								skip = skip + clen;
								clen = 16'd0;
							end
						end
						cont_left = clen;
						skip_cnt = skip;
						fr_state = (clen != 0 || skip != 0) ? FR_PAYLOAD : FR_HEAD;
					end
				end
			end
			FR_PAYLOAD: begin
				if (cont_left != 0) begin
					cont_left--;
					if (err_on)
						want_out(KIND_ERR_BYTE, b);
					else if (rphase == RD_HEADERS) begin
						if (b == LF_BYTE) begin
							if (line_text) begin
								line_text = 1'b0;
								want_out(KIND_HDR_BYTE, b);
							end else begin
								rphase = cfg_no_body ? RD_NOBODY : RD_BODY;
								line_text = 1'b0;
								want_out(KIND_HDR_DONE, 8'h00);
							end
						end else begin
							if (b == 8'h00 || b > SPACE_BYTE)
								line_text = 1'b1;
							want_out(KIND_HDR_BYTE, b);
						end
					end else if (rphase == RD_BODY)
						want_out(KIND_BODY_BYTE, b);
				end else if (skip_cnt != 0)
					skip_cnt--;
				if (cont_left == 0 && skip_cnt == 0)
					fr_state = FR_HEAD;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata);
				n_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					s_axis_tdata <= stream_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// hold off once for a long stretch so the block backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (!held && n_accepted >= 120) begin
				held <= 1'b1;
				hold_left <= 96;
			end else if (hold_left != 0)
				hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				kind_cnt[m_axis_tuser]++;
				n_out++;
				if (pending_out.size() == 0) begin
					$display("%0t: expected no item, got kind %0d byte %02h",
						$time, m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = pending_out.pop_front();
					if (m_axis_tuser !== want.kind || m_axis_tdata !== want.data) begin
						$display("%0t: expected kind %0d byte %02h, got kind %0d byte %02h",
							$time, want.kind, want.data, m_axis_tuser, m_axis_tdata);
						errors++;
					end
				end
			end
			if (hold_left != 0)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		stream_q.push_back(b);
		n_pushed++;
	endtask

	task automatic add_random(input int unsigned n);
		repeat (n) content_q.push_back(8'($urandom));
	endtask

	// header text that never closes the header block
	task automatic add_text(input int unsigned n);
		logic [7:0] b;
		repeat (n) begin
			if (gen_text && $urandom_range(0, 5) == 0) begin
				content_q.push_back(LF_BYTE);
				gen_text = 1'b0;
			end else begin
				b = 8'($urandom);
				if (b == LF_BYTE)
					b = 8'h00;
				if (b == 8'h00 || b > SPACE_BYTE)
					gen_text = 1'b1;
				content_q.push_back(b);
			end
		end
	endtask

	task automatic emit_record(input logic [7:0] rtype, input logic [15:0] rid,
			input logic [7:0] pad);
		logic [15:0] clen;
		clen = 16'(content_q.size());
		push_byte(8'($urandom));
		push_byte(rtype);
		push_byte(rid[15:8]);
		push_byte(rid[7:0]);
		push_byte(clen[15:8]);
		push_byte(clen[7:0]);
		push_byte(pad);
		push_byte(8'($urandom));
		while (content_q.size() != 0)
			push_byte(content_q.pop_front());
		repeat (pad) push_byte(8'($urandom));
	endtask

	task automatic random_record();
		int unsigned pick;
		logic [15:0] rid;
		logic [7:0] rtype;
		logic [7:0] pad;
		pick = $urandom_range(0, 99);
		pad = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255)) : 8'($urandom_range(0, 3));
		rid = 16'($urandom);
		if (rid == own_id)
			rid = ~rid;
		if (pick < 45) begin
			if (hdr_done_gen)
				add_random($urandom_range(0, 16));
			else
				add_text($urandom_range(0, 14));
			emit_record(REC_STDOUT, own_id, pad);
		end else if (pick < 60) begin
			add_random($urandom_range(0, 10));
			emit_record(REC_STDERR, own_id, pad);
		end else if (pick < 75) begin
			case ($urandom_range(0, 3))
				0: rtype = REC_REQ_END;
				1: rtype = REC_STDOUT;
				2: rtype = REC_STDERR;
				default: rtype = 8'($urandom);
			endcase
			if ($urandom_range(0, 9) == 0)
				add_random($urandom_range(200, 320));
			else
				add_random($urandom_range(0, 12));
			emit_record(rtype, rid, pad);
		end else if (pick < 88) begin
			rtype = 8'($urandom);
			if (rtype == REC_REQ_END || rtype == REC_STDOUT || rtype == REC_STDERR)
				rtype = rtype ^ 8'h80;
			add_random($urandom_range(0, 12));
			emit_record(rtype, own_id, pad);
		end else begin
			add_random($urandom_range(0, 2));
			emit_record(REC_REQ_END, rid, pad);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OWN_ID)
			own_id = val;
		else
			cfg_no_body = val[0];
	endtask

	task automatic drain();
		while (n_accepted != n_pushed || pending_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [7:0] ws;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		early_end = ($urandom_range(0, 3) == 0);

		// foreign stdout record with a lone newline, padded
		content_q.push_back(LF_BYTE);
		emit_record(REC_STDOUT, 16'd2, 8'd1);
		// unknown type on own id
		content_q.push_back(LF_BYTE);
		emit_record(8'hff, 16'd1, 8'd0);
		// zero byte counts as text, so the newline is a header byte
		content_q.push_back(8'h00);
		content_q.push_back(LF_BYTE);
		emit_record(REC_STDOUT, 16'd1, 8'd0);
		// stderr newline and space leave line tracking alone
		content_q.push_back(LF_BYTE);
		content_q.push_back(SPACE_BYTE);
		emit_record(REC_STDERR, 16'd1, 8'd2);
		// one header line spread over two records, then an empty record
		content_q.push_back(8'hff);
		emit_record(REC_STDOUT, 16'd1, 8'd0);
		content_q.push_back(SPACE_BYTE);
		content_q.push_back(LF_BYTE);
		emit_record(REC_STDOUT, 16'd1, 8'd0);
		emit_record(REC_STDOUT, 16'd1, 8'd0);
		// end of another request
		emit_record(REC_REQ_END, 16'd0, 8'd0);
		drain();

		write_reg(CFG_OWN_ID, 16'hffff);
		write_reg(CFG_NO_BODY, 16'd1);
		while (n_pushed < 240)
			random_record();
		drain();

		send_idle = 57;
		recv_idle = 30;
		write_reg(CFG_OWN_ID, 16'h0000);
		write_reg(CFG_NO_BODY, {15'd0, $urandom_range(0, 2) == 0});
		repeat (4) random_record();
		if (!early_end) begin
			// close the header block with a whitespace-only line, body follows
			add_text($urandom_range(0, 6));
			if (gen_text)
				content_q.push_back(LF_BYTE);
			repeat ($urandom_range(0, 3)) begin
				ws = 8'($urandom_range(1, 32));
				if (ws == LF_BYTE)
					ws = SPACE_BYTE;
				content_q.push_back(ws);
			end
			content_q.push_back(LF_BYTE);
			gen_text = 1'b0;
			add_random($urandom_range(0, 10));
			emit_record(REC_STDOUT, own_id, 8'($urandom_range(0, 3)));
			hdr_done_gen = 1'b1;
		end
		while (n_pushed < 400)
			random_record();
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_OWN_ID, 16'($urandom_range(2, 16'hfffe)));
		write_reg(CFG_NO_BODY, 16'd0);
		while (n_pushed < 500)
			random_record();
		emit_record(REC_REQ_END, ~own_id, 8'd0);
		emit_record(REC_REQ_END, own_id, 8'd0);
		// everything after the end is dropped
		add_random(6);
		emit_record(REC_STDOUT, own_id, 8'd1);
		emit_record(REC_REQ_END, own_id, 8'd0);
		drain();

		$display("Fed %0d bytes, checked %0d items: %0d header, %0d body, %0d stderr bytes.",
			n_accepted, n_out, kind_cnt[KIND_HDR_BYTE], kind_cnt[KIND_BODY_BYTE],
			kind_cnt[KIND_ERR_BYTE]);
		$display("Headers done %0d, response end %0d, premature end %0d, no-body mode %0d.",
			kind_cnt[KIND_HDR_DONE], kind_cnt[KIND_RESP_END], kind_cnt[KIND_EARLY_END],
			rphase == RD_NOBODY);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
